@@ src/yoc_pkg.sv @@
// Shared constants, types and CORDIC table for the yaw offset calibrator.
// No dependencies.
package yoc_pkg;

   localparam int DELAY_DEPTH_DEF = 5;
   localparam int ANGLE_BITS_DEF  = 16;
   localparam int CSTEPS          = 16;
   localparam int UNIT_START      = 9949;
   localparam int SUM_BITS        = 21;

   localparam logic [2:0] CSR_ALWAYS   = 3'd0;
   localparam logic [2:0] CSR_MISMATCH = 3'd1;
   localparam logic [2:0] CSR_STILL    = 3'd2;
   localparam logic [2:0] CSR_QUALIFY  = 3'd3;
   localparam logic [2:0] CSR_REST     = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture beat, run qualifiers
      logic rot_start;  // start rotation CORDIC
      logic rot_sel;    // 0 imu, 1 vision
      logic acc_add;    // add rotated vector to sums
      logic vec_start;  // start vectoring CORDIC
      logic vec_sel;    // 0 vision sums, 1 imu sums
      logic vec_store;  // store vision angle
      logic finish;     // commit tick, build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic do_acc;
      logic do_upd;
      logic cordic_done;
   } status_type;

   function automatic logic [31:0] atan_entry(input logic [3:0] i);
      logic [31:0] r;
      case (i)
         4'd0:  r = 32'd536870912;
         4'd1:  r = 32'd316933406;
         4'd2:  r = 32'd167458907;
         4'd3:  r = 32'd85004756;
         4'd4:  r = 32'd42667331;
         4'd5:  r = 32'd21354465;
         4'd6:  r = 32'd10679838;
         4'd7:  r = 32'd5340245;
         4'd8:  r = 32'd2670163;
         4'd9:  r = 32'd1335087;
         4'd10: r = 32'd667544;
         4'd11: r = 32'd333772;
         4'd12: r = 32'd166886;
         4'd13: r = 32'd83443;
         4'd14: r = 32'd41722;
         4'd15: r = 32'd20861;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

@@ src/yaw_offset_calibrator.sv @@
// Top level of the yaw offset calibrator: controller plus datapath.
// Depends on yoc_pkg, yoc_ctrl and yoc_dp.
//
// One beat in, one beat out. A beat with no sum due passes the qualify,
// decide and finish states only; a beat while unit vectors are accumulated
// takes two 16-step rotation passes of the shared CORDIC, and an offset
// update takes two 16-step vectoring passes. The CORDIC iterates one step a
// cycle and is the rate limit. A new beat is taken once the previous result
// has been handed on or is still waiting with rsp_stall low. Registers are
// written on csr_write and must only change while the block is idle.
module yaw_offset_calibrator
   import yoc_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
   parameter int ANGLE_BITS  = ANGLE_BITS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_imu_yaw,
   input  logic signed [15:0] req_vision_yaw,
   input  logic               req_vision_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_corrected_yaw,
   output logic               rsp_mismatch_flag,
   output logic               rsp_still_flag,
   output logic               rsp_offset_updated,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data
);
   cmd_type    cmd;
   status_type sts;

   // sequencer
   yoc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   // arithmetic and state
   yoc_dp #(.DELAY_DEPTH(DELAY_DEPTH), .ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_imu_yaw, .req_vision_yaw, .req_vision_valid,
      .rsp_corrected_yaw, .rsp_mismatch_flag, .rsp_still_flag,
      .rsp_offset_updated
   );
endmodule

@@ src/yoc_ctrl.sv @@
// Sequencer for the yaw offset calibrator.
// Depends on yoc_pkg.
module yoc_ctrl
   import yoc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_QUAL, S_DECIDE, S_ROT_I, S_ROT_I_W, S_ROT_V, S_ROT_V_W,
      S_VEC_V, S_VEC_V_W, S_VEC_I, S_VEC_I_W, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_QUAL;
            end
         end
         // qualifiers commit at the end of this cycle
         S_QUAL: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.do_acc) begin
               cmd.rot_start = 1'b1;
               state_in = S_ROT_I_W;
            end else if (sts.do_upd) begin
               cmd.vec_start = 1'b1;
               state_in = S_VEC_V_W;
            end else begin
               state_in = S_FIN;
            end
         end
         S_ROT_I_W: if (sts.cordic_done) begin
            cmd.acc_add = 1'b1;
            state_in = S_ROT_V;
         end
         S_ROT_V: begin
            cmd.rot_start = 1'b1;
            cmd.rot_sel   = 1'b1;
            state_in = S_ROT_V_W;
         end
         S_ROT_V_W: begin
            cmd.rot_sel = 1'b1;
            if (sts.cordic_done) begin
               cmd.acc_add = 1'b1;
               state_in = S_FIN;
            end
         end
         S_VEC_V_W: if (sts.cordic_done) begin
            cmd.vec_store = 1'b1;
            state_in = S_VEC_I;
         end
         S_VEC_I: begin
            cmd.vec_start = 1'b1;
            cmd.vec_sel   = 1'b1;
            state_in = S_VEC_I_W;
         end
         S_VEC_I_W: if (sts.cordic_done) state_in = S_FIN;
         S_FIN: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ src/yoc_dp.sv @@
// Datapath: qualifiers, delay line, shared CORDIC, sums and offset.
// Depends on yoc_pkg.
module yoc_dp
   import yoc_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
   parameter int ANGLE_BITS  = ANGLE_BITS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data,
   input  logic signed [15:0] req_imu_yaw,
   input  logic signed [15:0] req_vision_yaw,
   input  logic               req_vision_valid,
   output logic signed [15:0] rsp_corrected_yaw,
   output logic               rsp_mismatch_flag,
   output logic               rsp_still_flag,
   output logic               rsp_offset_updated
);
   localparam int AB = ANGLE_BITS;
   localparam int PW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam logic [AB-1:0] AHALF = {1'b1, {(AB-1){1'b0}}};
   localparam int CW = 34;  // CORDIC x/y width: sum*256 < 2^30, growth ok
   localparam logic [PW-1:0] PLAST = PW'(DELAY_DEPTH - 1);

   typedef logic [AB-1:0] ang_type;

   // configuration
   logic        always_ff_r;
   logic [14:0] mth_ff, sth_ff;
   logic [3:0]  qlim_ff;
   logic [4:0]  rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         always_ff_r <= 1'b1;
         mth_ff      <= 15'd182;
         sth_ff      <= 15'd104;
         qlim_ff     <= 4'd10;
         rest_ff     <= 5'd20;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ALWAYS:   always_ff_r <= csr_data[0];
            CSR_MISMATCH: mth_ff      <= csr_data;
            CSR_STILL:    sth_ff      <= csr_data;
            CSR_QUALIFY:  qlim_ff     <= csr_data[3:0];
            CSR_REST:     rest_ff     <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   function automatic ang_type wmag(input ang_type d);
      return (d >= AHALF) ? ang_type'(~d + 1'b1) : d;
   endfunction

   // captured beat
   ang_type imu_ff, vis_ff;
   logic    valid_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         imu_ff   <= ang_type'(req_imu_yaw);
         vis_ff   <= ang_type'(req_vision_yaw);
         valid_ff <= req_vision_valid;
      end
   end

   // state
   ang_type         offset_ff, sref_ff;
   ang_type         dline_ff [DELAY_DEPTH];
   logic [PW-1:0]   dptr_ff;
   logic [4:0]      rcnt_ff;
   logic [3:0]      mcnt_ff, scnt_ff;
   logic            mst_ff, sst_ff, mflag_ff, upd_ff;
   logic signed [SUM_BITS-1:0] isc_ff, iss_ff, vsc_ff, vss_ff;
   logic            do_acc_ff, do_upd_ff;
   ang_type         av_ff;

   // qualifiers, evaluated from registered state in the cycle after load
   logic            qual_ff;
   ang_type         mdiff, sdiff;
   logic            mbig, sclose;
   logic [4:0]      mn, sn;
   logic [4:0]      rs;
   logic            mflag, sflag;
   logic            mst_n, sst_n, sref_upd;

   always_comb begin
      mdiff = vis_ff - (dline_ff[dptr_ff] + offset_ff);
      sdiff = sref_ff - imu_ff;
      mbig   = wmag(mdiff) > ang_type'(mth_ff);
      sclose = wmag(sdiff) < ang_type'(sth_ff);
      mst_n  = mst_ff;
      mn     = mbig ? {1'b0, mcnt_ff} + 5'd1 : 5'd0;
      if (!mbig) mst_n = 1'b0;
      if (mn > {1'b0, qlim_ff}) begin
         mn = 5'd0; mst_n = 1'b1;
      end
      mflag = always_ff_r ? 1'b1 : mst_n;
      sst_n = sst_ff;
      sref_upd = !sclose;
      sn    = sclose ? {1'b0, scnt_ff} + 5'd1 : 5'd0;
      if (!sclose) sst_n = 1'b0;
      if (sn > {1'b0, qlim_ff}) begin
         sn = 5'd0; sst_n = 1'b1; sref_upd = 1'b1;
      end
      sflag = sst_n;
      rs    = (rest_ff > 5'd30) ? 5'd30 : rest_ff;
   end

   // shared CORDIC: rotation or vectoring
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [31:0]          cz_ff;
   logic [3:0]           ci_ff;
   logic                 cbusy_ff, cmode_ff, cdone_ff, czero_ff;
   logic signed [CW-1:0] shx, shy, rx, ry;
   logic [31:0]          rz, za;
   logic                 dir;
   logic signed [SUM_BITS-1:0] vx, vy;
   ang_type              vec_ang;

   always_comb begin
      shx = cx_ff >>> ci_ff;
      shy = cy_ff >>> ci_ff;
      za  = atan_entry(ci_ff);
      dir = cmode_ff ? !(cy_ff > 0) : !cz_ff[31];
      // dir=1: x-=y, y+=x
      rx  = dir ? cx_ff - shy : cx_ff + shy;
      ry  = dir ? cy_ff + shx : cy_ff - shx;
      if (cmode_ff) rz = dir ? cz_ff - za : cz_ff + za;
      else          rz = dir ? cz_ff - za : cz_ff + za;
      vec_ang = czero_ff ? '0 :
         ang_type'((cz_ff + (32'd1 << (31 - AB))) >> (32 - AB));
   end

   // rotated result with quadrant fix
   logic [1:0]           rq_ff;
   logic signed [CW-1:0] ox, oy;
   always_comb begin
      case (rq_ff)
         2'd1:    begin ox = -cy_ff; oy = cx_ff;  end
         2'd2:    begin ox = -cx_ff; oy = -cy_ff; end
         2'd3:    begin ox = cy_ff;  oy = -cx_ff; end
         default: begin ox = cx_ff;  oy = cy_ff;  end
      endcase
   end

   ang_type rang;
   logic [31:0] rz0;
   logic signed [SUM_BITS-1:0] sx, sy;
   always_comb begin
      rang = cmd.rot_sel ? vis_ff : imu_ff;
      rz0  = {rang, {(32 - AB){1'b0}}};
      sx   = cmd.vec_sel ? isc_ff : vsc_ff;
      sy   = cmd.vec_sel ? iss_ff : vss_ff;
      vx   = sx;
      vy   = sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cbusy_ff <= 1'b0;
         cdone_ff <= 1'b0;
      end else begin
         cdone_ff <= 1'b0;
         if (cmd.rot_start) begin
            cbusy_ff <= 1'b1;
            cmode_ff <= 1'b0;
            ci_ff    <= '0;
            cx_ff    <= CW'(UNIT_START);
            cy_ff    <= '0;
            cz_ff    <= {2'b00, rz0[29:0]};
            rq_ff    <= rz0[31:30];
         end else if (cmd.vec_start) begin
            cbusy_ff <= 1'b1;
            cmode_ff <= 1'b1;
            ci_ff    <= '0;
            czero_ff <= (vx == 0) && (vy == 0);
            if (vx < 0) begin
               cx_ff <= -(CW'(vx) <<< 8);
               cy_ff <= -(CW'(vy) <<< 8);
               cz_ff <= 32'h8000_0000;
            end else begin
               cx_ff <= CW'(vx) <<< 8;
               cy_ff <= CW'(vy) <<< 8;
               cz_ff <= '0;
            end
         end else if (cbusy_ff) begin
            cx_ff <= rx;
            cy_ff <= ry;
            cz_ff <= rz;
            ci_ff <= ci_ff + 4'd1;
            if (ci_ff == 4'(CSTEPS - 1)) begin
               cbusy_ff <= 1'b0;
               cdone_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.do_acc      = do_acc_ff;
   assign sts.do_upd      = do_upd_ff;
   assign sts.cordic_done = cdone_ff;

   // qualifier commit, sums, offset
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sref_ff   <= '0;
         dptr_ff   <= '0;
         rcnt_ff   <= '0;
         mcnt_ff   <= '0;
         scnt_ff   <= '0;
         mst_ff    <= 1'b0;
         sst_ff    <= 1'b0;
         isc_ff    <= '0;
         iss_ff    <= '0;
         vsc_ff    <= '0;
         vss_ff    <= '0;
         qual_ff   <= 1'b0;
         do_acc_ff <= 1'b0;
         do_upd_ff <= 1'b0;
         upd_ff    <= 1'b0;
         mflag_ff  <= 1'b0;
         for (int i = 0; i < DELAY_DEPTH; i++) dline_ff[i] <= '0;
      end else begin
         qual_ff <= cmd.load;
         if (qual_ff) begin
            if (!always_ff_r) begin
               mcnt_ff <= mn[3:0];
               mst_ff  <= mst_n;
            end
            mflag_ff <= mflag;
            scnt_ff  <= sn[3:0];
            sst_ff   <= sst_n;
            if (sref_upd) sref_ff <= imu_ff;
            upd_ff   <= 1'b0;
            if (mflag && sflag && valid_ff) begin
               do_acc_ff <= !(rcnt_ff > rs);
               do_upd_ff <= rcnt_ff > rs;
            end else begin
               do_acc_ff <= 1'b0;
               do_upd_ff <= 1'b0;
               rcnt_ff   <= '0;
               isc_ff <= '0; iss_ff <= '0; vsc_ff <= '0; vss_ff <= '0;
            end
         end
         if (cmd.acc_add) begin
            if (cmd.rot_sel) begin
               vsc_ff  <= vsc_ff + SUM_BITS'(ox);
               vss_ff  <= vss_ff + SUM_BITS'(oy);
               rcnt_ff <= rcnt_ff + 5'd1;
            end else begin
               isc_ff <= isc_ff + SUM_BITS'(ox);
               iss_ff <= iss_ff + SUM_BITS'(oy);
            end
         end
         if (cmd.vec_store) av_ff <= vec_ang;
         if (cmd.finish) begin
            if (do_upd_ff) begin
               offset_ff <= av_ff - vec_ang;
               rcnt_ff   <= '0;
               upd_ff    <= 1'b1;
               isc_ff <= '0; iss_ff <= '0; vsc_ff <= '0; vss_ff <= '0;
            end
            dline_ff[dptr_ff] <= imu_ff;
            dptr_ff <= (dptr_ff == PLAST) ? '0 : dptr_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_corrected_yaw  <= 16'(imu_ff + (do_upd_ff ? av_ff - vec_ang : offset_ff));
         rsp_mismatch_flag  <= mflag_ff;
         rsp_still_flag     <= sst_ff;
         rsp_offset_updated <= do_upd_ff;
      end
   end

   logic unused;
   assign unused = upd_ff;
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for yaw_offset_calibrator: directed table, zero-vector run,
// then random beats under several idle/stall phases, checked against an in-bench
// predictor. Depends on yoc_pkg and the calibrator RTL.
module testbench;
   import yoc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_imu_yaw = '0;
   logic signed [15:0] req_vision_yaw = '0;
   logic               req_vision_valid = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_corrected_yaw;
   logic               rsp_mismatch_flag;
   logic               rsp_still_flag;
   logic               rsp_offset_updated;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [14:0]        csr_data = '0;

   always #6 clock = ~clock;

   yaw_offset_calibrator dut (.*);

   // one result beat
   typedef struct packed {
      logic [15:0] yaw;
      logic        mis;
      logic        still;
      logic        upd;
   } yaw_result_type;

   // directed stimulus row; has_exp marks rows with a hand-written answer
   typedef struct {
      logic [15:0] imu;
      logic [15:0] vis;
      logic        vv;
      logic        has_exp;
      yaw_result_type exp;
   } yaw_row_type;

   // ---- predictor state: copy of the block's registers and state ----
   logic        cal_always;
   logic [14:0] cal_mis_thr, cal_still_thr;
   logic [3:0]  cal_qual;
   logic [4:0]  cal_rest;
   logic [15:0] offset_q, still_ref_q;
   logic [4:0]  rest_cnt_q;
   longint      isum_c, isum_s, vsum_c, vsum_s;
   logic [3:0]  mis_cnt_q, still_cnt_q;
   logic        mis_st_q, still_st_q;
   logic [15:0] delay_q [5];
   int          delay_ptr_q;

   yaw_result_type expected_results [$];
   yaw_result_type typed_answers [$];   // hand-written answers, kept in step
   logic        typed_valid [$];

   int errors = 0, beats_in = 0, beats_out = 0, updates_seen = 0;
   int idle_pct = 0, stall_pct = 0;
   bit long_hold = 1'b0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
      errors++;
   endtask

   function automatic longint fshift(input longint v, input int s);
      return v >>> s;  // arithmetic shift on longint is a floor shift
   endfunction

   function automatic logic [15:0] wrap_mag16(input logic [15:0] d);
      return d[15] ? (16'hFFFF - d) + 16'd1 : d;
   endfunction

   // rotation CORDIC: unit vector of a binary angle, amplitude 16384
   task automatic rotate_unit(input logic [15:0] ang, output longint c, output longint s);
      logic [31:0] z;
      longint r, x, y, nx, ny;
      z = {ang, 16'h0};
      r = longint'(z[29:0]);
      x = UNIT_START; y = 0;
      for (int i = 0; i < CSTEPS; i++) begin
         if (r >= 0) begin
            nx = x - fshift(y, i); ny = y + fshift(x, i); r -= atan_entry(4'(i));
         end else begin
            nx = x + fshift(y, i); ny = y - fshift(x, i); r += atan_entry(4'(i));
         end
         x = nx; y = ny;
      end
      case (z[31:30])
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         2'd3: begin c = y;  s = -x; end
         default: begin c = x; s = y; end
      endcase
   endtask

   // vectoring CORDIC: direction of a summed vector
   function automatic logic [15:0] direction_of(input longint cx, input longint sy);
      longint x, y, nx, ny;
      logic [31:0] z;
      if (cx == 0 && sy == 0) return 16'd0;
      x = cx * 256; y = sy * 256; z = 0;
      if (x < 0) begin x = -x; y = -y; z = 32'h8000_0000; end
      for (int i = 0; i < CSTEPS; i++) begin
         if (y > 0) begin
            nx = x + fshift(y, i); ny = y - fshift(x, i); z += atan_entry(4'(i));
         end else begin
            nx = x - fshift(y, i); ny = y + fshift(x, i); z -= atan_entry(4'(i));
         end
         x = nx; y = ny;
      end
      z += 32'h0000_8000;
      return z[31:16];
   endfunction

   function automatic void predictor_reset();
      cal_always = 1'b1; cal_mis_thr = 15'd182; cal_still_thr = 15'd104;
      cal_qual = 4'd10; cal_rest = 5'd20;
      offset_q = '0; still_ref_q = '0; rest_cnt_q = '0;
      isum_c = 0; isum_s = 0; vsum_c = 0; vsum_s = 0;
      mis_cnt_q = '0; still_cnt_q = '0; mis_st_q = 1'b0; still_st_q = 1'b0;
      foreach (delay_q[i]) delay_q[i] = '0;
      delay_ptr_q = 0;
   endfunction

   // advance the predictor by one tick and return the expected result
   task automatic predict_tick(input logic [15:0] imu, input logic [15:0] vis,
                               input logic vv, output yaw_result_type res);
      logic [15:0] d;
      logic [4:0]  n, rs;
      logic        mf, sf, upd;
      longint      c, s;
      upd = 1'b0;
      if (cal_always) mf = 1'b1;
      else begin
         d = vis - (delay_q[delay_ptr_q] + offset_q);
         n = {1'b0, mis_cnt_q};
         if (wrap_mag16(d) > {1'b0, cal_mis_thr}) n++;
         else begin n = '0; mis_st_q = 1'b0; end
         if (n > {1'b0, cal_qual}) begin n = '0; mis_st_q = 1'b1; end
         mis_cnt_q = n[3:0];
         mf = mis_st_q;
      end
      n = {1'b0, still_cnt_q};
      if (wrap_mag16(still_ref_q - imu) < {1'b0, cal_still_thr}) n++;
      else begin n = '0; still_ref_q = imu; still_st_q = 1'b0; end
      if (n > {1'b0, cal_qual}) begin n = '0; still_ref_q = imu; still_st_q = 1'b1; end
      still_cnt_q = n[3:0];
      sf = still_st_q;
      rs = (cal_rest > 5'd30) ? 5'd30 : cal_rest;
      if (mf && sf && vv) begin
         if (rest_cnt_q > rs) begin
            offset_q = direction_of(vsum_c, vsum_s) - direction_of(isum_c, isum_s);
            rest_cnt_q = '0; isum_c = 0; isum_s = 0; vsum_c = 0; vsum_s = 0;
            upd = 1'b1;
         end else begin
            rotate_unit(imu, c, s); isum_c += c; isum_s += s;
            rotate_unit(vis, c, s); vsum_c += c; vsum_s += s;
            rest_cnt_q++;
         end
      end else begin
         rest_cnt_q = '0; isum_c = 0; isum_s = 0; vsum_c = 0; vsum_s = 0;
      end
      res.yaw = imu + offset_q; res.mis = mf; res.still = sf; res.upd = upd;
      delay_q[delay_ptr_q] = imu;
      delay_ptr_q = (delay_ptr_q + 1 >= 5) ? 0 : delay_ptr_q + 1;
   endtask

   // ---- result checker, samples at the rising edge ----
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("MISMATCH unexpected result beat %0d", beats_out);
            errors++;
         end else begin
            yaw_result_type e;
            e = expected_results.pop_front();
            if (rsp_corrected_yaw !== e.yaw)
               report_mismatch("corrected_yaw", rsp_corrected_yaw, $signed(e.yaw));
            if (rsp_mismatch_flag !== e.mis)  report_mismatch("mismatch_flag", rsp_mismatch_flag, e.mis);
            if (rsp_still_flag !== e.still)   report_mismatch("still_flag", rsp_still_flag, e.still);
            if (rsp_offset_updated !== e.upd) report_mismatch("offset_updated", rsp_offset_updated, e.upd);
            // a typed answer, where present, must agree with the predictor too
            if (typed_valid.size() != 0) begin
               if (typed_valid.pop_front() && typed_answers[0] !== e) begin
                  $display("MISMATCH directed answer differs at beat %0d", beats_out);
                  errors++;
               end
               void'(typed_answers.pop_front());
            end
            if (rsp_offset_updated) updates_seen++;
         end
         beats_out++;
      end
   end

   // watchdog: count cycles with no accepted beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stall, or one long hold to back the block up
   always @(negedge clock) begin
      if (long_hold) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ALWAYS:   cal_always    = val[0];
         CSR_MISMATCH: cal_mis_thr   = val;
         CSR_STILL:    cal_still_thr = val;
         CSR_QUALIFY:  cal_qual      = val[3:0];
         CSR_REST:     cal_rest      = val[4:0];
         default: ;
      endcase
   endtask

   // offer one beat; valid stays high back to back when no gap is drawn
   task automatic send_beat(input logic [15:0] imu, input logic [15:0] vis, input logic vv);
      yaw_result_type r;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_imu_yaw <= imu; req_vision_yaw <= vis;
      req_vision_valid <= vv;
      do @(posedge clock); while (req_stall);
      predict_tick(imu, vis, vv, r);
      expected_results.push_back(r);
      beats_in++;
      @(negedge clock);
   endtask

   task automatic release_channel();
      req_valid <= 1'b0;
   endtask

   // sender pauses until every expected result is in, plus latency margin
   task automatic drain();
      release_channel();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // settled sequence: stable imu and vision a fixed angle apart, random content
   task automatic calib_run(input int count);
      logic [15:0] base, gap;
      base = $urandom; gap = $urandom;
      for (int i = 0; i < count; i++) begin
         logic [15:0] jit;
         jit = $urandom_range(6) - 3;
         send_beat(base + jit, base + gap + jit, ($urandom_range(15) != 0));
      end
   endtask

   task automatic random_phase(input int count);
      int done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(9) < 7) begin
            int len;
            len = $urandom_range(14, 40);
            calib_run(len); done += len;
         end else begin
            send_beat($urandom, $urandom, $urandom_range(1)); done++;
         end
      end
   endtask

   yaw_row_type directed [$];

   function automatic yaw_row_type mk(input logic [15:0] imu, input logic [15:0] vis,
                                   input logic vv, input logic he,
                                   input logic [15:0] ey, input logic em,
                                   input logic es, input logic eu);
      yaw_row_type r;
      r.imu = imu; r.vis = vis; r.vv = vv; r.has_exp = he;
      r.exp = '{yaw: ey, mis: em, still: es, upd: eu};
      return r;
   endfunction

   initial begin
      predictor_reset();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed table: after reset the offset is zero and mismatch is forced
      directed.push_back(mk(16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0));
      directed.push_back(mk(16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 1'b1, 1'b0, 1'b0));
      directed.push_back(mk(16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b0, 1'b0));
      directed.push_back(mk(16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0));
      directed.push_back(mk(16'h0000, 16'h8000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0));
      // half-turn difference against the still reference
      directed.push_back(mk(16'h8000, 16'h0000, 1'b1, 1'b0, '0, 0, 0, 0));
      directed.push_back(mk(16'h0000, 16'h0000, 1'b1, 1'b0, '0, 0, 0, 0));
      for (int i = 0; i < 16; i++)
         directed.push_back(mk(16'h4000, (i < 8) ? 16'h4000 : 16'hC000, 1'b1, 1'b0, '0, 0, 0, 0));

      write_reg(CSR_QUALIFY, 15'd1);
      write_reg(CSR_REST, 15'd1);
      foreach (directed[i]) begin
         typed_valid.push_back(directed[i].has_exp);
         typed_answers.push_back(directed[i].exp);
         send_beat(directed[i].imu, directed[i].vis, directed[i].vv);
      end
      drain();

      // zero vector: opposite vectors sum to nothing, qualify limit of zero
      write_reg(CSR_QUALIFY, 15'd0);
      for (int i = 0; i < 6; i++) send_beat(16'h0000, (i % 2) ? 16'h8000 : 16'h0000, 1'b1);
      drain();

      // phases: settings and idling change only while drained
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 45; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         write_reg(CSR_ALWAYS, (p < 3) ? 15'd1 : 15'($urandom_range(1)));
         write_reg(CSR_MISMATCH, (p == 4) ? 15'd0 : (p == 5) ? 15'h7FFF : 15'($urandom_range(400)));
         write_reg(CSR_STILL, (p == 6) ? 15'h7FFF : (p == 7) ? 15'd0 : 15'($urandom_range(20, 300)));
         write_reg(CSR_QUALIFY, (p == 0) ? 15'd15 : (p == 1) ? 15'd1 : 15'($urandom_range(1, 6)));
         write_reg(CSR_REST, (p == 2) ? 15'd30 : (p == 3) ? 15'd31 : 15'($urandom_range(1, 8)));
         if (p == 2) begin
            // receiver holds off long enough for the block to back up
            fork
               begin long_hold = 1'b1; repeat (400) @(negedge clock); long_hold = 1'b0; end
            join_none
         end
         random_phase(185);
         drain();
      end

      $display("Covered %0d beats in, %0d results, %0d offset updates", beats_in, beats_out,
               updates_seen);
      $display("Register extremes, forced and live mismatch, four idle/stall mixes");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
